// File: hw/rtl/mdpg_pkg.sv
// ----------------------------------------------------------------------------
// mdpg_pkg: shared definitions for the midpoint disc pixel generator
// Coordinate and radius widths, derived field widths and command codes.
// ----------------------------------------------------------------------------
package mdpg_pkg;

   // coordinate and radius widths
   localparam int COORD_BITS  = 12;
   localparam int RADIUS_BITS = 8;

   // derived widths of the walk state
   localparam int WALK_BITS = RADIUS_BITS + 2;
   localparam int STEP_BITS = RADIUS_BITS + 3;
   localparam int ERR_BITS  = RADIUS_BITS + 5;
   localparam int PIX_BITS  = COORD_BITS + 2;
   localparam int SUM_BITS  = ((PIX_BITS > WALK_BITS) ? PIX_BITS : WALK_BITS) + 1;

   // stream payload widths, padded to whole bytes
   localparam int REQ_FIELD_BITS = 2 * COORD_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * PIX_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // reset radius of the disc
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(8);

   // command codes carried on req_tuser
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_NEXT  = 1'b1;

   // final mirror of the eight octants
   localparam logic [2:0] OCT_LAST = 3'd7;

   typedef logic [COORD_BITS-1:0]         coord_type;
   typedef logic [RADIUS_BITS-1:0]        radius_type;
   typedef logic signed [WALK_BITS-1:0]   walk_type;
   typedef logic signed [STEP_BITS-1:0]   step_type;
   typedef logic signed [ERR_BITS-1:0]    err_type;
   typedef logic signed [PIX_BITS-1:0]    pix_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;

endpackage

// File: hw/rtl/midpoint_disc_pixel_generator.sv
// ----------------------------------------------------------------------------
// midpoint_disc_pixel_generator: filled disc as concentric midpoint circles
// A start transfer latches the center, opening ring 1 if radius > 1; a next
// transfer emits an octant mirror and steps the walk, or flags last if idle.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                 tuser         tlast
//  req      in   center_x, center_y                 func          -
//  rsp      out  pixel_x, pixel_y, zero pad         pixel_valid   last_pixel
//  csr      in   csr_wdata = disc_radius, written when csr_we is high
//
//  one request transfer per cycle while req_tready is high; its result
//  appears in the response register on the next cycle, set by the octant
//  mirror of the state registers (a mux and one narrow add).
//  req_tready is low only while a response is held and rsp_tready is low.
//  synchronous active-high reset clears the walk (idle) and sets radius 8.
//
module midpoint_disc_pixel_generator (
   input  logic                              clock,
   input  logic                              reset,
   // request: center_x [11:0], center_y [23:12]
   input  logic [mdpg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // request: func [0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // response: pixel_x [13:0], pixel_y [27:14], zero pad above
   output logic [mdpg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // response: pixel_valid [0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // configuration: disc_radius
   input  logic                              csr_we,
   input  logic [mdpg_pkg::RADIUS_BITS-1:0]   csr_wdata
);

   // configuration and walk state
   mdpg_pkg::radius_type radius_ff;
   mdpg_pkg::coord_type  center_col_ff, center_col_in;
   mdpg_pkg::coord_type  center_row_ff, center_row_in;
   mdpg_pkg::radius_type ring_ff, ring_in;
   mdpg_pkg::walk_type   walk_x_ff, walk_x_in;
   mdpg_pkg::walk_type   walk_y_ff, walk_y_in;
   mdpg_pkg::step_type   step_tx_ff, step_tx_in;
   mdpg_pkg::step_type   step_ty_ff, step_ty_in;
   mdpg_pkg::err_type    error_ff, error_in;
   logic [2:0]           octant_ff, octant_in;
   logic                 active_ff, active_in;

   // response register
   logic                 rsp_valid_ff;
   mdpg_pkg::pix_type    rsp_px_ff, rsp_px_in;
   mdpg_pkg::pix_type    rsp_py_ff, rsp_py_in;
   logic                 rsp_pv_ff, rsp_pv_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;

   // mirror and update terms
   mdpg_pkg::sum_type    cx_s, cy_s, x_s, y_s, a_s, b_s, px_s, py_s;
   mdpg_pkg::err_type    two_r;
   logic                 err_le0, err1_gt0;
   mdpg_pkg::err_type    err1, err2;
   mdpg_pkg::walk_type   x1, y1;
   mdpg_pkg::step_type   tx1, ty1;
   logic [mdpg_pkg::RADIUS_BITS:0] ring_next;

   // output register parts the two sides
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // octant mirror of the current point
   assign cx_s = mdpg_pkg::SUM_BITS'($signed({1'b0, center_col_ff}));
   assign cy_s = mdpg_pkg::SUM_BITS'($signed({1'b0, center_row_ff}));
   assign x_s  = mdpg_pkg::SUM_BITS'(walk_x_ff);
   assign y_s  = mdpg_pkg::SUM_BITS'(walk_y_ff);
   assign a_s  = octant_ff[2] ? y_s : x_s;
   assign b_s  = octant_ff[2] ? x_s : y_s;
   assign px_s = octant_ff[1] ? (cx_s - a_s) : (cx_s + a_s);
   assign py_s = octant_ff[0] ? (cy_s + b_s) : (cy_s - b_s);

   // error update after the eighth mirror
   assign two_r    = mdpg_pkg::ERR_BITS'({ring_ff, 1'b0});
   assign err_le0  = error_ff[mdpg_pkg::ERR_BITS-1] || (error_ff == '0);
   assign err1     = err_le0 ? (error_ff + mdpg_pkg::ERR_BITS'(step_ty_ff)) : error_ff;
   assign y1       = err_le0 ? (walk_y_ff + mdpg_pkg::WALK_BITS'(1)) : walk_y_ff;
   assign ty1      = err_le0 ? (step_ty_ff + mdpg_pkg::STEP_BITS'(2)) : step_ty_ff;
   assign err1_gt0 = !err1[mdpg_pkg::ERR_BITS-1] && (err1 != '0);
   assign tx1      = err1_gt0 ? (step_tx_ff + mdpg_pkg::STEP_BITS'(2)) : step_tx_ff;
   assign x1       = err1_gt0 ? (walk_x_ff - mdpg_pkg::WALK_BITS'(1)) : walk_x_ff;
   assign err2     = err1_gt0 ? (err1 + mdpg_pkg::ERR_BITS'(tx1) - two_r) : err1;
   assign ring_next = {1'b0, ring_ff} + (mdpg_pkg::RADIUS_BITS + 1)'(1);

   // next walk state and response
   always_comb begin
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      ring_in       = ring_ff;
      walk_x_in     = walk_x_ff;
      walk_y_in     = walk_y_ff;
      step_tx_in    = step_tx_ff;
      step_ty_in    = step_ty_ff;
      error_in      = error_ff;
      octant_in     = octant_ff;
      active_in     = active_ff;
      rsp_px_in     = '0;
      rsp_py_in     = '0;
      rsp_pv_in     = 1'b0;
      rsp_last_in   = 1'b0;
      if (req_tuser == mdpg_pkg::FUNC_START) begin
         center_col_in = req_tdata[mdpg_pkg::COORD_BITS-1:0];
         center_row_in = req_tdata[2*mdpg_pkg::COORD_BITS-1:mdpg_pkg::COORD_BITS];
         step_tx_in    = mdpg_pkg::STEP_BITS'(1);
         step_ty_in    = mdpg_pkg::STEP_BITS'(1);
         walk_y_in     = '0;
         octant_in     = '0;
         if (radius_ff > mdpg_pkg::RADIUS_BITS'(1)) begin
            ring_in   = mdpg_pkg::RADIUS_BITS'(1);
            walk_x_in = '0;
            error_in  = -mdpg_pkg::ERR_BITS'(1);
            active_in = 1'b1;
         end else begin
            ring_in   = '0;
            walk_x_in = -mdpg_pkg::WALK_BITS'(1);
            error_in  = mdpg_pkg::ERR_BITS'(1);
            active_in = 1'b0;
         end
      end else if (!active_ff) begin
         rsp_last_in = 1'b1;
      end else begin
         rsp_px_in = mdpg_pkg::PIX_BITS'(px_s);
         rsp_py_in = mdpg_pkg::PIX_BITS'(py_s);
         rsp_pv_in = 1'b1;
         if (octant_ff != mdpg_pkg::OCT_LAST) begin
            octant_in = octant_ff + 3'd1;
         end else begin
            octant_in  = '0;
            walk_x_in  = x1;
            walk_y_in  = y1;
            step_tx_in = tx1;
            step_ty_in = ty1;
            error_in   = err2;
            if (x1 < y1) begin
               if (ring_next >= {1'b0, radius_ff}) begin
                  active_in   = 1'b0;
                  rsp_last_in = 1'b1;
               end else begin
                  // open the next ring: x = r-1, error = 1-2r
                  ring_in    = ring_next[mdpg_pkg::RADIUS_BITS-1:0];
                  walk_x_in  = mdpg_pkg::WALK_BITS'(ring_ff);
                  walk_y_in  = '0;
                  step_tx_in = mdpg_pkg::STEP_BITS'(1);
                  step_ty_in = mdpg_pkg::STEP_BITS'(1);
                  error_in   = ~two_r;
               end
            end
         end
      end
   end

   // control and walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= mdpg_pkg::RADIUS_RESET;
         center_col_ff <= '0;
         center_row_ff <= '0;
         ring_ff       <= '0;
         walk_x_ff     <= '0;
         walk_y_ff     <= '0;
         step_tx_ff    <= mdpg_pkg::STEP_BITS'(1);
         step_ty_ff    <= mdpg_pkg::STEP_BITS'(1);
         error_ff      <= '0;
         octant_ff     <= '0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            radius_ff <= csr_wdata;
         end
         if (accept) begin
            center_col_ff <= center_col_in;
            center_row_ff <= center_row_in;
            ring_ff       <= ring_in;
            walk_x_ff     <= walk_x_in;
            walk_y_ff     <= walk_y_in;
            step_tx_ff    <= step_tx_in;
            step_ty_ff    <= step_ty_in;
            error_ff      <= error_in;
            octant_ff     <= octant_in;
            active_ff     <= active_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_px_ff   <= rsp_px_in;
         rsp_py_ff   <= rsp_py_in;
         rsp_pv_ff   <= rsp_pv_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mdpg_pkg::RSP_DATA_BITS'({rsp_py_ff, rsp_px_ff});
   assign rsp_tuser  = rsp_pv_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // a walk in mid-ring is always an active one
   assert property (@(posedge clock) disable iff (reset)
      (octant_ff != 3'd0) |-> active_ff)
      else $error("octant advanced while walk idle");

   // an active walk never sits on the empty ring
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (ring_ff != '0))
      else $error("active walk on invalid ring");

   // no pixel means zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pv_ff) |-> (rsp_px_ff == '0) && (rsp_py_ff == '0))
      else $error("coordinates set without a pixel");

   // the final pixel closes the walk
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pv_ff && rsp_last_ff) |-> !active_ff)
      else $error("last pixel while walk still active");

   // a start transfer yields an empty, non-final response
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == mdpg_pkg::FUNC_START) |=> (!rsp_pv_ff && !rsp_last_ff))
      else $error("start response not empty");
`endif

endmodule

// File: tb/tb_midpoint_disc_pixel_generator.sv
// ----------------------------------------------------------------------------
// tb_midpoint_disc_pixel_generator: self-checking bench for the disc generator
// Drives start and next transfers with random gaps and response stalls,
// predicts every pixel of the concentric ring walk and checks each response
// transfer field by field. Radius changes are made while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_midpoint_disc_pixel_generator;
   timeunit 1ns;
   timeprecision 1ps;

   // one response transfer as the bench sees it
   typedef struct packed {
      mdpg_pkg::pix_type px;
      mdpg_pkg::pix_type py;
      logic              valid;
      logic              last;
   } pixel_result_type;

   // one row of the directed table
   typedef struct packed {
      int                  radius;   // negative: leave the radius register alone
      logic                func;
      mdpg_pkg::coord_type cx;
      mdpg_pkg::coord_type cy;
      bit                  typed;    // compare against res instead of the predictor
      pixel_result_type    res;
   } stim_row_type;

   localparam pixel_result_type IDLE_RES  = '{px: '0, py: '0, valid: 1'b0, last: 1'b1};
   localparam pixel_result_type START_RES = '{px: '0, py: '0, valid: 1'b0, last: 1'b0};
   localparam pixel_result_type NO_RES    = '0;

   localparam int RANDOM_ITEMS = 825;
   localparam int QUIET_FROM   = RANDOM_ITEMS - 100;
   localparam int WALK_LIMIT   = 3000;

   logic                               clock;
   logic                               reset;
   logic [mdpg_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic                               req_tuser;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [mdpg_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tuser;
   logic                               rsp_tlast;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b1;
   logic                               csr_we;
   logic [mdpg_pkg::RADIUS_BITS-1:0]   csr_wdata;

   midpoint_disc_pixel_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // bench copy of the radius register and the ring walk
   int                  radius_setting = int'(mdpg_pkg::RADIUS_RESET);
   mdpg_pkg::coord_type center_col = '0;
   mdpg_pkg::coord_type center_row = '0;
   int                  ring_r = 0;
   int                  walk_x = 0;
   int                  walk_y = 0;
   int                  step_tx = 1;
   int                  step_ty = 1;
   int                  walk_err = 0;
   int                  octant = 0;
   bit                  walk_busy = 0;

   pixel_result_type expected_pixels[$];
   stim_row_type     stim_rows[$];
   int               mismatch_count = 0;
   int               items_sent = 0;
   bit               idle_on = 0;
   int               stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous run limit
   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic void open_ring(int r);
      ring_r   = r;
      walk_x   = r - 1;
      walk_y   = 0;
      step_tx  = 1;
      step_ty  = 1;
      walk_err = 1 - 2 * r;
      octant   = 0;
   endfunction

   // next pixel of the disc walk for one accepted request
   function automatic pixel_result_type predict_pixel(logic func,
                                                      mdpg_pkg::coord_type cx_in,
                                                      mdpg_pkg::coord_type cy_in);
      pixel_result_type res;
      int px, py, cx, cy;
      res = '0;
      px  = 0;
      py  = 0;
      if (func == mdpg_pkg::FUNC_START) begin
         center_col = cx_in;
         center_row = cy_in;
         open_ring(0);
         walk_busy = 0;
         // ring 0 is empty, go straight to ring 1
         if (radius_setting > 1) begin
            open_ring(1);
            walk_busy = 1;
         end
      end else if (!walk_busy) begin
         res.last = 1'b1;
      end else begin
         cx = int'(center_col);
         cy = int'(center_row);
         case (octant)
            0: begin px = cx + walk_x; py = cy - walk_y; end
            1: begin px = cx + walk_x; py = cy + walk_y; end
            2: begin px = cx - walk_x; py = cy - walk_y; end
            3: begin px = cx - walk_x; py = cy + walk_y; end
            4: begin px = cx + walk_y; py = cy - walk_x; end
            5: begin px = cx + walk_y; py = cy + walk_x; end
            6: begin px = cx - walk_y; py = cy - walk_x; end
            default: begin px = cx - walk_y; py = cy + walk_x; end
         endcase
         res.valid = 1'b1;
         if (octant < int'(mdpg_pkg::OCT_LAST)) begin
            octant++;
         end else begin
            // two error updates after the eighth mirror
            octant = 0;
            if (walk_err <= 0) begin
               walk_y++;
               walk_err += step_ty;
               step_ty  += 2;
            end
            if (walk_err > 0) begin
               walk_x--;
               step_tx  += 2;
               walk_err += step_tx - 2 * ring_r;
            end
            // ring done: next ring or end of disc
            if (walk_x < walk_y) begin
               if (ring_r + 1 >= radius_setting) begin
                  walk_busy = 0;
                  res.last  = 1'b1;
               end else begin
                  open_ring(ring_r + 1);
               end
            end
         end
      end
      res.px = mdpg_pkg::pix_type'(px);
      res.py = mdpg_pkg::pix_type'(py);
      return res;
   endfunction

   // one request transfer; entered and left at a falling edge
   task automatic send_req(logic func, mdpg_pkg::coord_type cx, mdpg_pkg::coord_type cy,
                           bit typed, pixel_result_type typed_res);
      pixel_result_type predicted;
      if (idle_on && items_sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tuser  <= func;
      req_tdata  <= mdpg_pkg::REQ_DATA_BITS'({cy, cx});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = predict_pixel(func, cx, cy);
      expected_pixels.push_back(typed ? typed_res : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // radius write once every response has come back
   task automatic write_radius(int r);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mdpg_pkg::RADIUS_BITS'(r);
      @(negedge clock);
      csr_we <= 1'b0;
      radius_setting = r;
   endtask

   function automatic int pick_radius();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 6)
         return $urandom_range(0, 1);
      else if (sel < 80)
         return $urandom_range(2, 10);
      else if (sel < 97)
         return $urandom_range(11, 24);
      else
         return $urandom_range(25, 255);
   endfunction

   function automatic mdpg_pkg::coord_type pick_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return mdpg_pkg::coord_type'($urandom_range(0, 4095));
      endcase
   endfunction

   // response stalls in random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && items_sent < QUIET_FROM && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each response transfer with the oldest expected pixel
   always @(posedge clock) begin : rsp_check
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected, data %h", rsp_tdata));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[mdpg_pkg::PIX_BITS-1:0] !== want.px)
               report_mismatch($sformatf("pixel_x got %0d want %0d",
                  $signed(rsp_tdata[mdpg_pkg::PIX_BITS-1:0]), want.px));
            if (rsp_tdata[2*mdpg_pkg::PIX_BITS-1:mdpg_pkg::PIX_BITS] !== want.py)
               report_mismatch($sformatf("pixel_y got %0d want %0d",
                  $signed(rsp_tdata[2*mdpg_pkg::PIX_BITS-1:mdpg_pkg::PIX_BITS]), want.py));
            if (rsp_tuser !== want.valid)
               report_mismatch($sformatf("pixel_valid got %b want %b", rsp_tuser, want.valid));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last_pixel got %b want %b", rsp_tlast, want.last));
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      int           limit;
      int           steps;
      bit           changed;
      int           guard;

      reset      = 1'b1;
      req_tdata  = '0;
      req_tuser  = mdpg_pkg::FUNC_START;
      req_tvalid = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = '0;

      // idle after reset, then default radius 8 from the origin
      stim_rows.push_back('{-1, mdpg_pkg::FUNC_NEXT, 12'h000, 12'h000, 1'b1, IDLE_RES});
      stim_rows.push_back('{-1, mdpg_pkg::FUNC_START, 12'h000, 12'h000, 1'b1, START_RES});
      repeat (5)
         stim_rows.push_back('{-1, mdpg_pkg::FUNC_NEXT, 12'hFFF, 12'hFFF, 1'b0, NO_RES});
      // radius 0 and 1 leave the block idle
      stim_rows.push_back('{0, mdpg_pkg::FUNC_START, 12'hFFF, 12'hFFF, 1'b1, START_RES});
      stim_rows.push_back('{-1, mdpg_pkg::FUNC_NEXT, 12'hFFF, 12'hFFF, 1'b1, IDLE_RES});
      stim_rows.push_back('{1, mdpg_pkg::FUNC_START, 12'hAAA, 12'h555, 1'b1, START_RES});
      stim_rows.push_back('{-1, mdpg_pkg::FUNC_NEXT, 12'h555, 12'hAAA, 1'b1, IDLE_RES});
      // largest radius, a few pixels only
      stim_rows.push_back('{255, mdpg_pkg::FUNC_START, 12'hFFF, 12'h000, 1'b1, START_RES});
      repeat (3)
         stim_rows.push_back('{-1, mdpg_pkg::FUNC_NEXT, 12'h000, 12'h000, 1'b0, NO_RES});
      // radius 2: one ring at the far corner, last pixel flagged, then idle
      stim_rows.push_back('{2, mdpg_pkg::FUNC_START, 12'hFFF, 12'hFFF, 1'b1, START_RES});
      repeat (9)
         stim_rows.push_back('{-1, mdpg_pkg::FUNC_NEXT, 12'h000, 12'h000, 1'b0, NO_RES});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.radius >= 0)
            write_radius(row.radius);
         send_req(row.func, row.cx, row.cy, row.typed, row.res);
      end

      // random discs, some cut short, some with a radius change mid-walk
      while (items_sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0)
            write_radius(pick_radius());
         send_req(mdpg_pkg::FUNC_START, pick_coord(), pick_coord(), 1'b0, NO_RES);
         limit   = (radius_setting > 24 || $urandom_range(0, 5) == 0) ?
                   $urandom_range(1, 300) : WALK_LIMIT;
         steps   = 0;
         changed = 0;
         while (walk_busy && steps < limit && items_sent < RANDOM_ITEMS) begin
            if (!changed && $urandom_range(0, 199) == 0) begin
               write_radius(pick_radius());
               changed = 1;
            end
            // next transfers carry random, ignored center fields
            send_req(mdpg_pkg::FUNC_NEXT, mdpg_pkg::coord_type'($urandom),
                     mdpg_pkg::coord_type'($urandom), 1'b0, NO_RES);
            steps++;
         end
         repeat ($urandom_range(0, 2))
            send_req(mdpg_pkg::FUNC_NEXT, mdpg_pkg::coord_type'($urandom),
                     mdpg_pkg::coord_type'($urandom), 1'b0, NO_RES);
      end

      // drain
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_pixels.size() != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      if (expected_pixels.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_pixels.size()));
      repeat (5) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
